// ===== sv/sise_pkg.sv =====
package sise_pkg;

  localparam int unsigned SET_DEPTH_DEF = 1024;

  localparam logic [63:0] MIX_ADD = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL = 64'h2545_f491_4f6c_dd1d;

  // action codes
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_REMOVE = 3'd1;
  localparam logic [2:0] ACT_FIND   = 3'd2;
  localparam logic [2:0] ACT_GET    = 3'd3;
  localparam logic [2:0] ACT_RANDOM = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // width classes
  localparam logic [1:0] CLS_16 = 2'd0;
  localparam logic [1:0] CLS_32 = 2'd1;
  localparam logic [1:0] CLS_64 = 2'd2;

  localparam int unsigned OUT_W = 224;
  localparam int unsigned IN_W  = 144;

endpackage

// ===== sv/sise_pick.sv =====
module sise_pick import sise_pkg::*; #(
  parameter int unsigned CW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [62:0]   seed_i,
  input  logic [CW-1:0] count_i,
  output logic          done_o,
  output logic [CW-1:0] pos_o
);

  typedef enum logic [2:0] {P_IDLE, P_MUL0, P_MUL1, P_MUL2, P_DIV} pick_state_e;

  pick_state_e state_q;
  logic [63:0] x_q, acc_q;
  logic [CW-1:0] rem_q;
  logic [5:0] step_q;
  logic done_q;

  logic [63:0] x0, x1, x2, x3;
  logic [CW:0] rem_sh, rem_sub;

  always_comb begin
    x0 = {1'b0, seed_i} + MIX_ADD;
    x1 = x0 ^ (x0 >> 12);
    x2 = x1 ^ (x1 << 25);
    x3 = x2 ^ (x2 >> 27);
    rem_sh = {rem_q, acc_q[63]};
    rem_sub = rem_sh - {1'b0, count_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        P_IDLE: begin
          if (start_i) begin
            x_q     <= x3;
            state_q <= P_MUL0;
          end
        end
        P_MUL0: begin
          acc_q   <= x_q[31:0] * MIX_MUL[31:0];
          state_q <= P_MUL1;
        end
        P_MUL1: begin
          acc_q   <= acc_q + {32'(x_q[63:32] * MIX_MUL[31:0]), 32'd0};
          state_q <= P_MUL2;
        end
        P_MUL2: begin
          acc_q   <= acc_q + {32'(x_q[31:0] * MIX_MUL[63:32]), 32'd0};
          rem_q   <= '0;
          step_q  <= 6'd63;
          state_q <= P_DIV;
        end
        P_DIV: begin
          // restoring remainder, one dividend bit a cycle
          if (rem_sh >= {1'b0, count_i}) rem_q <= rem_sub[CW-1:0];
          else rem_q <= rem_sh[CW-1:0];
          acc_q  <= acc_q << 1;
          step_q <= step_q - 6'd1;
          if (step_q == 6'd0) begin
            done_q  <= 1'b1;
            state_q <= P_IDLE;
          end
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign pos_o  = rem_q;

endmodule

// ===== sv/sorted_int_set_engine_core.sv =====
// channel   | dir | signals                         | contents
// s_axis    | in  | tvalid tready tdata[143:0] tuser | one action item
// m_axis    | out | tvalid tready tdata[223:0]       | one result item per action
//
// one item at a time; the entries sit in a single-port-read memory with a separate write port
// search: binary search, each probe a read in S_SRCH and a compare in S_SCMP
// add/remove: search, then a read state and a write state per shifted entry
// random pick: multiply states MUL0, MUL1, MUL2, then 64 remainder steps
// every item ends with two memory reads for smallest and largest unless the set is empty
// reset clears count and class; memory contents are not cleared
// the result register lets the next item in while a result waits on m_axis_tready
module sorted_int_set_engine_core import sise_pkg::*; #(
  parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // operand_value[63:0], entry_index[73:64], pick_seed[136:74], zero pad
  input  logic [IN_W-1:0]   s_axis_tdata,
  // action[2:0]
  input  logic [2:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // status[1:0], hit[2], position[13:3], entry_value[77:14], entry_count[88:78],
  // width_class[90:89], smallest[154:91], largest[218:155], zero pad
  output logic [OUT_W-1:0]  m_axis_tdata
);

  localparam int unsigned AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SET_DEPTH + 1);
  localparam int unsigned PW = (CW > 11) ? CW : 11;
  localparam logic [CW-1:0] DEPTH_C = CW'(SET_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SCMP, S_SHUP_RD, S_SHUP_WR, S_INS, S_SHDN_RD, S_SHDN_WR,
    S_PICK, S_VRD, S_VCAP, S_MIN, S_MAX, S_MAXC, S_OUT
  } state_e;

  state_e state_q;

  // working registers for the current item
  logic [2:0]    act_q;
  logic [63:0]   opv_q;
  logic [62:0]   seed_q;
  logic [CW-1:0] count_q, lo_q, hi_q, mid_q, ptr_q;
  logic [1:0]    cls_q, status_q;
  logic          hit_q;
  logic [PW-1:0] pos_q;
  logic [63:0]   value_q, min_q, max_q;
  logic          pick_start_q;

  // result register
  logic          out_valid_q;
  logic [218:0]  out_q;

  // entry memory
  logic [63:0]   mem [SET_DEPTH];
  logic [63:0]   rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [63:0]   wdata;

  logic          pick_done;
  logic [CW-1:0] pick_pos;

  logic [CW-1:0] mid;
  logic [1:0]    op_cls;
  logic          accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign mid           = lo_q + ((hi_q - lo_q) >> 1);

  // narrowest class that holds the operand
  always_comb begin
    if (opv_q[63:31] != {33{1'b0}} && opv_q[63:31] != {33{1'b1}}) op_cls = CLS_64;
    else if (opv_q[31:15] != {17{1'b0}} && opv_q[31:15] != {17{1'b1}}) op_cls = CLS_32;
    else op_cls = CLS_16;
  end

  // memory port usage per state
  always_comb begin
    raddr = '0;
    waddr = '0;
    we    = 1'b0;
    wdata = rdata_q;
    unique case (state_q)
      S_SRCH:    raddr = mid[AW-1:0];
      S_SHUP_RD: raddr = AW'(ptr_q - CW'(1));
      S_SHUP_WR: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
      end
      S_INS: begin
        we    = 1'b1;
        waddr = pos_q[AW-1:0];
        wdata = opv_q;
      end
      S_SHDN_RD: raddr = AW'(ptr_q + CW'(1));
      S_SHDN_WR: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0];
      end
      S_VRD:     raddr = pos_q[AW-1:0];
      S_MIN:     raddr = '0;
      S_MAX:     raddr = AW'(count_q - CW'(1));
      default:   raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  sise_pick #(.CW(CW)) u_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pick_start_q),
    .seed_i  (seed_q),
    .count_i (count_q),
    .done_o  (pick_done),
    .pos_o   (pick_pos)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      cls_q        <= CLS_16;
      out_valid_q  <= 1'b0;
      pick_start_q <= 1'b0;
    end else begin
      pick_start_q <= 1'b0;
      // the output state reloads the result register itself
      if (out_valid_q && m_axis_tready && state_q != S_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            act_q    <= s_axis_tuser;
            opv_q    <= s_axis_tdata[63:0];
            seed_q   <= s_axis_tdata[136:74];
            status_q <= ST_OK;
            hit_q    <= 1'b0;
            value_q  <= '0;
            pos_q    <= '0;
            lo_q     <= '0;
            hi_q     <= count_q;
            unique case (s_axis_tuser)
              ACT_ADD: begin
                if (count_q >= DEPTH_C) begin
                  status_q <= ST_FULL;
                  state_q  <= S_MIN;
                end else begin
                  state_q <= S_SRCH;
                end
              end
              ACT_REMOVE, ACT_FIND: state_q <= S_SRCH;
              ACT_GET: begin
                pos_q <= PW'(s_axis_tdata[73:64]);
                if (PW'(s_axis_tdata[73:64]) >= PW'(count_q)) begin
                  status_q <= ST_RANGE;
                  state_q  <= S_MIN;
                end else begin
                  state_q <= S_VRD;
                end
              end
              ACT_RANDOM: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  state_q  <= S_MIN;
                end else begin
                  pick_start_q <= 1'b1;
                  state_q      <= S_PICK;
                end
              end
              default: state_q <= S_MIN;
            endcase
          end
        end
        S_SRCH: begin
          mid_q <= mid;
          if (lo_q < hi_q) begin
            state_q <= S_SCMP;
          end else begin
            // absent: insertion point is lo
            pos_q <= PW'(lo_q);
            if (act_q == ACT_ADD) begin
              if (op_cls > cls_q) cls_q <= op_cls;
              ptr_q <= count_q;
              if (count_q > lo_q) state_q <= S_SHUP_RD;
              else state_q <= S_INS;
            end else begin
              state_q <= S_MIN;
            end
          end
        end
        S_SCMP: begin
          if ($signed(opv_q) > $signed(rdata_q)) begin
            lo_q    <= mid_q + CW'(1);
            state_q <= S_SRCH;
          end else if ($signed(opv_q) < $signed(rdata_q)) begin
            hi_q    <= mid_q;
            state_q <= S_SRCH;
          end else begin
            pos_q <= PW'(mid_q);
            if (act_q == ACT_REMOVE) begin
              ptr_q <= mid_q;
              if (mid_q + CW'(1) < count_q) begin
                state_q <= S_SHDN_RD;
              end else begin
                count_q <= count_q - CW'(1);
                hit_q   <= 1'b1;
                state_q <= S_MIN;
              end
            end else begin
              // find hits; duplicate add does not
              hit_q   <= (act_q == ACT_FIND);
              state_q <= S_MIN;
            end
          end
        end
        S_SHUP_RD: state_q <= S_SHUP_WR;
        S_SHUP_WR: begin
          ptr_q <= ptr_q - CW'(1);
          if (PW'(ptr_q - CW'(1)) > pos_q) state_q <= S_SHUP_RD;
          else state_q <= S_INS;
        end
        S_INS: begin
          count_q <= count_q + CW'(1);
          hit_q   <= 1'b1;
          state_q <= S_MIN;
        end
        S_SHDN_RD: state_q <= S_SHDN_WR;
        S_SHDN_WR: begin
          ptr_q <= ptr_q + CW'(1);
          if ((CW+1)'(ptr_q) + (CW+1)'(2) < (CW+1)'(count_q)) begin
            state_q <= S_SHDN_RD;
          end else begin
            count_q <= count_q - CW'(1);
            hit_q   <= 1'b1;
            state_q <= S_MIN;
          end
        end
        S_PICK: begin
          if (pick_done) begin
            pos_q   <= PW'(pick_pos);
            state_q <= S_VRD;
          end
        end
        S_VRD: state_q <= S_VCAP;
        S_VCAP: begin
          value_q <= rdata_q;
          state_q <= S_MIN;
        end
        S_MIN: begin
          if (count_q == '0) begin
            min_q   <= '0;
            max_q   <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_MAX;
          end
        end
        S_MAX: begin
          min_q   <= rdata_q;
          state_q <= S_MAXC;
        end
        S_MAXC: begin
          max_q   <= rdata_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_q       <= {max_q, min_q, cls_q, 11'(count_q), value_q,
                            pos_q[10:0], hit_q, status_q};
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_W-219){1'b0}}, out_q};

endmodule

// ===== sv/sise_checker.sv =====
module sise_checker import sise_pkg::*; #(
  parameter int unsigned SET_DEPTH = SET_DEPTH_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic [2:0]       s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a waiting item holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("item changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // class code never takes the unused value
  a_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[90:89] != 2'd3)
    else $error("bad width class");

  // an error status never comes with a hit
  a_err_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> !m_axis_tdata[2])
    else $error("hit on error status");

  // full flag only when the count shows a full set
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == ST_FULL |->
      m_axis_tdata[88:78] == 11'(SET_DEPTH))
    else $error("full flag with room left");

endmodule

bind sorted_int_set_engine_core sise_checker #(.SET_DEPTH(SET_DEPTH)) u_sise_checker (.*);
